>>> sv/fltw_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
package fltw_pkg;

  localparam int unsigned AddrW  = 64;
  localparam int unsigned PaW    = 52;
  localparam int unsigned IdxW   = 9;
  localparam int unsigned EntryB = 3;   // log2 of the entry size in bytes

  // bits 51..12 of a root or an entry hold the frame
  localparam logic [AddrW-1:0] FrameMask = 64'h000F_FFFF_FFFF_F000;
  localparam logic [AddrW-1:0] OffsetMask = 64'h0000_0000_0000_0FFF;
  localparam int unsigned LargeBit = 7;

  typedef enum logic [1:0] {
    KIND_READ  = 2'd0,
    KIND_DONE  = 2'd1,
    KIND_FAULT = 2'd2
  } kind_t;

  typedef enum logic [2:0] {
    CAUSE_NONE      = 3'd0,
    CAUSE_BAD_ROOT  = 3'd1,
    CAUSE_NONCANON  = 3'd2,
    CAUSE_NOT_PRES  = 3'd3,
    CAUSE_READ_ERR  = 3'd4,
    CAUSE_TOP_LARGE = 3'd5
  } cause_t;

  typedef enum logic [1:0] {
    SIZE_4K = 2'd0,
    SIZE_2M = 2'd1,
    SIZE_1G = 2'd2
  } size_t_t;

  // one classified transaction, as it travels from front to back
  typedef struct packed {
    logic             is_req;
    cause_t           cause;   // fault found without walk state
    logic             big_page;
    logic [AddrW-1:0] base;    // table root, or entry frame bits in place
    logic [AddrW-1:0] va;      // request address, requests only
  } entry_t;

  localparam int unsigned EntryW = $bits(entry_t);

endpackage
`default_nettype wire

>>> sv/fltw_front.sv
`timescale 1ns / 1ps
`default_nettype none
module fltw_front
  import fltw_pkg::*;
(
  input  wire logic             req_type,
  input  wire logic [AddrW-1:0] table_root,
  input  wire logic [AddrW-1:0] virtual_address,
  input  wire logic [AddrW-1:0] read_data,
  input  wire logic             read_ok,
  output entry_t                classified
);

  logic root_bad;
  logic canon;

  // canonical: bits 63..47 all equal
  assign canon    = (&virtual_address[AddrW-1:47]) | ~(|virtual_address[AddrW-1:47]);
  assign root_bad = ((table_root & FrameMask) == '0) | ((table_root & OffsetMask) != '0);

  always_comb begin
    classified.is_req   = ~req_type;
    classified.va       = virtual_address;
    classified.big_page = read_data[LargeBit];
    if (!req_type) begin
      classified.base = table_root;
      if (root_bad) begin
        classified.cause = CAUSE_BAD_ROOT;
      end else if (!canon) begin
        classified.cause = CAUSE_NONCANON;
      end else begin
        classified.cause = CAUSE_NONE;
      end
    end else begin
      classified.base = read_data & FrameMask;
      // read error is checked before the present bit
      if (!read_ok) begin
        classified.cause = CAUSE_READ_ERR;
      end else if (!read_data[0]) begin
        classified.cause = CAUSE_NOT_PRES;
      end else begin
        classified.cause = CAUSE_NONE;
      end
    end
  end

endmodule
`default_nettype wire

>>> sv/fltw_queue.sv
`timescale 1ns / 1ps
`default_nettype none
module fltw_queue
  import fltw_pkg::*;
(
  input  wire logic   clk,
  input  wire logic   rst,
  input  wire logic   push,
  input  wire entry_t push_data,
  output logic        full,
  output logic        pop_valid,
  output entry_t      pop_data,
  input  wire logic   pop
);

  entry_t     slots [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] count;
  logic [1:0] count_next;

  assign full      = (count == 2'd2);
  assign pop_valid = (count != 2'd0);
  assign pop_data  = slots[rd_ptr];

  always_comb begin
    count_next = count;
    if (push && !(pop && pop_valid)) begin
      count_next = count + 2'd1;
    end else if (!push && pop && pop_valid) begin
      count_next = count - 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      count <= count_next;
      if (push) begin
        wr_ptr <= ~wr_ptr;
      end
      if (pop && pop_valid) begin
        rd_ptr <= ~rd_ptr;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_data;
    end
  end

endmodule
`default_nettype wire

>>> sv/fltw_back.sv
`timescale 1ns / 1ps
`default_nettype none
module fltw_back
  import fltw_pkg::*;
(
  input  wire logic         clk,
  input  wire logic         rst,
  input  wire logic         q_valid,
  input  wire entry_t       q_data,
  output logic              q_pop,
  output logic              result_valid,
  input  wire logic         result_stall,
  output logic [1:0]        result_kind,
  output logic [AddrW-1:0]  read_address,
  output logic [PaW-1:0]    phys_addr,
  output logic [1:0]        mapped_size,
  output logic [2:0]        fault_cause
);

  typedef enum logic [4:0] {
    LVL_IDLE = 5'b00001,
    LVL_4    = 5'b00010,
    LVL_3    = 5'b00100,
    LVL_2    = 5'b01000,
    LVL_1    = 5'b10000
  } level_t;

  level_t           walk_level;
  level_t           walk_level_next;
  logic [AddrW-1:0] held_address;
  logic [AddrW-1:0] held_address_next;

  logic             make;
  kind_t            kind_next;
  logic [AddrW-1:0] rd_base;
  logic [IdxW-1:0]  rd_idx;
  logic [AddrW-1:0] rd_addr_next;
  logic [PaW-1:0]   pa_next;
  size_t_t          size_next;
  cause_t           cause_next;

  assign q_pop = q_valid && (!result_valid || !result_stall);

  assign rd_addr_next = rd_base + {{(AddrW-IdxW-EntryB){1'b0}}, rd_idx, {EntryB{1'b0}}};

  always_comb begin
    walk_level_next   = walk_level;
    held_address_next = held_address;
    make       = 1'b0;
    kind_next  = KIND_READ;
    rd_base    = '0;
    rd_idx     = '0;
    pa_next    = '0;
    size_next  = SIZE_4K;
    cause_next = CAUSE_NONE;
    if (q_data.is_req) begin
      make = 1'b1;
      walk_level_next = LVL_IDLE;
      if (q_data.cause != CAUSE_NONE) begin
        kind_next  = KIND_FAULT;
        cause_next = q_data.cause;
      end else begin
        held_address_next = q_data.va;
        rd_base   = q_data.base;
        rd_idx    = q_data.va[47:39];
        walk_level_next = LVL_4;
      end
    end else if (walk_level != LVL_IDLE) begin
      make = 1'b1;
      if (q_data.cause != CAUSE_NONE) begin
        kind_next  = KIND_FAULT;
        cause_next = q_data.cause;
        walk_level_next = LVL_IDLE;
      end else begin
        unique case (walk_level)
          LVL_4: begin
            if (q_data.big_page) begin
              kind_next  = KIND_FAULT;
              cause_next = CAUSE_TOP_LARGE;
              walk_level_next = LVL_IDLE;
            end else begin
              rd_base = q_data.base;
              rd_idx  = held_address[38:30];
              walk_level_next = LVL_3;
            end
          end
          LVL_3: begin
            if (q_data.big_page) begin
              kind_next = KIND_DONE;
              pa_next   = {q_data.base[PaW-1:30], held_address[29:0]};
              size_next = SIZE_1G;
              walk_level_next = LVL_IDLE;
            end else begin
              rd_base = q_data.base;
              rd_idx  = held_address[29:21];
              walk_level_next = LVL_2;
            end
          end
          LVL_2: begin
            if (q_data.big_page) begin
              kind_next = KIND_DONE;
              pa_next   = {q_data.base[PaW-1:21], held_address[20:0]};
              size_next = SIZE_2M;
              walk_level_next = LVL_IDLE;
            end else begin
              rd_base = q_data.base;
              rd_idx  = held_address[20:12];
              walk_level_next = LVL_1;
            end
          end
          default: begin
            kind_next = KIND_DONE;
            pa_next   = {q_data.base[PaW-1:12], held_address[11:0]};
            size_next = SIZE_4K;
            walk_level_next = LVL_IDLE;
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      walk_level   <= LVL_IDLE;
      held_address <= '0;
      result_valid <= 1'b0;
    end else begin
      if (q_pop) begin
        walk_level   <= walk_level_next;
        held_address <= held_address_next;
      end
      if (q_pop && make) begin
        result_valid <= 1'b1;
      end else if (!result_stall) begin
        result_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop && make) begin
      result_kind  <= kind_next;
      read_address <= (kind_next == KIND_READ) ? rd_addr_next : '0;
      phys_addr    <= pa_next;
      mapped_size  <= size_next;
      fault_cause  <= cause_next;
    end
  end

endmodule
`default_nettype wire

>>> sv/four_level_page_table_walker_core.sv
`timescale 1ns / 1ps
`default_nettype none
// Four-level page-table walker. Requests (req_type 0) and entry read responses
// (req_type 1) share one input channel; each input transaction gives zero or one
// result transaction: an entry read request, a finished translation (1G, 2M or 4K)
// or a fault. A new request abandons any walk in progress; a response while idle
// is dropped. One input transaction is taken every cycle in steady state while
// the result side is not stalled. Each input first passes through the two-entry
// queue behind the classifier; the walk stage then registers its result, which is
// offered on result_valid. The single 64-bit add of base and index in the walk
// stage sets the clock path.
module four_level_page_table_walker_core
  import fltw_pkg::*;
(
  input  wire logic             clk,
  input  wire logic             rst,
  // input channel
  input  wire logic             item_valid,
  output logic                  item_stall,
  input  wire logic             req_type,
  input  wire logic [AddrW-1:0] table_root,
  input  wire logic [AddrW-1:0] virtual_address,
  input  wire logic [AddrW-1:0] read_data,
  input  wire logic             read_ok,
  // result channel
  output logic                  result_valid,
  input  wire logic             result_stall,
  output logic [1:0]            result_kind,
  output logic [AddrW-1:0]      read_address,
  output logic [PaW-1:0]        phys_addr,
  output logic [1:0]            mapped_size,
  output logic [2:0]            fault_cause
);

  entry_t classified;
  entry_t q_data;
  logic   q_full;
  logic   q_valid;
  logic   q_pop;

  // front: root, canonical and entry checks need no walk state
  fltw_front u_front (
    .req_type        (req_type),
    .table_root      (table_root),
    .virtual_address (virtual_address),
    .read_data       (read_data),
    .read_ok         (read_ok),
    .classified      (classified)
  );

  // stall only when both queue slots are taken
  assign item_stall = q_full;

  fltw_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (item_valid && !item_stall),
    .push_data (classified),
    .full      (q_full),
    .pop_valid (q_valid),
    .pop_data  (q_data),
    .pop       (q_pop)
  );

  // back: walk level, held address, next read address and final mapping
  fltw_back u_back (
    .clk          (clk),
    .rst          (rst),
    .q_valid      (q_valid),
    .q_data       (q_data),
    .q_pop        (q_pop),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .result_kind  (result_kind),
    .read_address (read_address),
    .phys_addr    (phys_addr),
    .mapped_size  (mapped_size),
    .fault_cause  (fault_cause)
  );

  // a fault always carries a cause
  a_fault_cause: assert property (@(posedge clk) disable iff (rst)
    (result_valid && result_kind == KIND_FAULT) |-> fault_cause != CAUSE_NONE)
    else $error("fault without cause");

  // entry reads are 8-byte aligned and carry no translation
  a_read_align: assert property (@(posedge clk) disable iff (rst)
    (result_valid && result_kind == KIND_READ) |->
      (read_address[2:0] == 3'd0 && phys_addr == '0))
    else $error("bad entry read");

  // a finished translation has no cause and no read address
  a_done_clean: assert property (@(posedge clk) disable iff (rst)
    (result_valid && result_kind == KIND_DONE) |->
      (fault_cause == CAUSE_NONE && read_address == '0))
    else $error("bad translation result");

  // with the result side free, the queue drains so input cannot stay stalled
  a_no_deadlock: assert property (@(posedge clk) disable iff (rst)
    (item_stall && !result_stall && $past(!result_stall) && !$past(rst)) |-> !$past(item_stall))
    else $error("input stalled while result side free");

endmodule
`default_nettype wire
